// ===== rtl/core/svmc_pkg.sv =====
// ----------------------------------------------------------------------------
// svmc_pkg
// Shared codes and fixed-point constants for the state vector measure unit.
// ----------------------------------------------------------------------------
`default_nettype none

package svmc_pkg;

  // item kinds
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_MEASURE = 2'd2;

  // result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_BAD_QUBIT = 2'd2;

  // parameter defaults
  localparam int DEF_MAX_QUBITS = 10;
  localparam int DEF_AMP_WIDTH  = 16;

  localparam logic [3:0] QCOUNT_RESET = 4'd10;

  // probability / divisor formats
  localparam int SQ_IN_W   = 62;   // radicand, P << 20
  localparam int SQ_OUT_W  = 31;   // sqrt(p) in Q.24
  localparam int SQ_SHIFT  = 20;
  localparam int DIV_FRAC  = 24;
  localparam int PC_W      = 41;   // chosen probability, capped at 2^40

endpackage

`default_nettype wire

// ===== rtl/core/svmc_sqrt.sv =====
// ----------------------------------------------------------------------------
// svmc_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module svmc_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [svmc_pkg::SQ_IN_W-1:0]  radicand,
  output logic                              done,
  output logic [svmc_pkg::SQ_OUT_W-1:0]      root
);
  import svmc_pkg::*;

  logic [SQ_IN_W-1:0] x;
  logic [SQ_IN_W-1:0] r;
  logic [SQ_IN_W-1:0] bt;
  logic [4:0]         cnt;
  logic               busy;
  logic [SQ_IN_W-1:0] trial;

  assign trial = r + bt;
  assign root  = SQ_OUT_W'(r);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= radicand;
        r    <= '0;
        bt   <= SQ_IN_W'(1) << (SQ_IN_W - 2);
        cnt  <= 5'(SQ_OUT_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (x >= trial) begin
          x <= x - trial;
          r <= (r >> 1) + bt;
        end else begin
          r <= r >> 1;
        end
        bt  <= bt >> 2;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/svmc_div.sv =====
// ----------------------------------------------------------------------------
// svmc_div
// Restoring divider: round((mag << 24) / d), quotient bits only, with overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module svmc_div #(
  parameter int AMP_WIDTH = svmc_pkg::DEF_AMP_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [AMP_WIDTH-1:0]          mag,
  input  wire logic [svmc_pkg::SQ_OUT_W-1:0] divisor,
  output logic                               done,
  output logic                               ovf,
  output logic [AMP_WIDTH-1:0]               quo
);
  import svmc_pkg::*;

  localparam int NW  = AMP_WIDTH + 25;
  localparam int CW  = $clog2(AMP_WIDTH + 1);

  logic [NW-1:0]        num;
  logic [SQ_OUT_W-1:0]  d;
  logic [SQ_OUT_W-1:0]  rem;
  logic [AMP_WIDTH-1:0] lo;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic [SQ_OUT_W:0]    rem2;

  assign num  = (NW'(mag) << DIV_FRAC) + NW'(divisor >> 1);
  assign rem2 = {rem, lo[AMP_WIDTH-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        d    <= divisor;
        ovf  <= (num >> AMP_WIDTH) >= NW'(divisor);
        rem  <= SQ_OUT_W'(num >> AMP_WIDTH);
        lo   <= num[AMP_WIDTH-1:0];
        quo  <= '0;
        cnt  <= CW'(AMP_WIDTH);
        busy <= 1'b1;
      end else if (busy) begin
        if (rem2 >= {1'b0, d}) begin
          rem <= SQ_OUT_W'(rem2 - {1'b0, d});
          quo <= {quo[AMP_WIDTH-2:0], 1'b1};
        end else begin
          rem <= SQ_OUT_W'(rem2);
          quo <= {quo[AMP_WIDTH-2:0], 1'b0};
        end
        lo  <= lo << 1;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/state_vector_measure_collapse_unit.sv =====
// ----------------------------------------------------------------------------
// state_vector_measure_collapse_unit
// Amplitude store with write, read and single-qubit projective measurement.
// ----------------------------------------------------------------------------
//
//  channel | signals                                    | transfer when
//  --------+--------------------------------------------+-------------------
//  cfg     | cfg_wr_en, cfg_wr_data (qubit_count)       | cfg_wr_en high
//  in      | in_valid/in_ready, kind .. random_fraction | in_valid & in_ready
//  out     | out_valid/out_ready, outcome .. status     | out_valid & out_ready
//
// Measure: a probability pass over the store (one shared multiplier, two squares
//   per entry), then the probability, a square root one bit per cycle, and a
//   collapse pass that divides both parts of each kept entry by the root and
//   zeroes the others.
// Reset: synchronous; qubit_count returns to 10. The store is not cleared.
// Stalls: in_ready is high only while idle; a finished result sits in the
//   output register, so the next item transfers while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module state_vector_measure_collapse_unit #(
  parameter int MAX_QUBITS = svmc_pkg::DEF_MAX_QUBITS,
  parameter int AMP_WIDTH  = svmc_pkg::DEF_AMP_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [9:0]  amp_index,
  input  wire logic signed [15:0] real_part,
  input  wire logic signed [15:0] imag_part,
  input  wire logic [3:0]  target_qubit,
  input  wire logic [15:0] random_fraction,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             outcome,
  output logic [16:0]      prob_zero,
  output logic signed [15:0] read_real,
  output logic signed [15:0] read_imag,
  output logic [1:0]       status
);
  import svmc_pkg::*;

  localparam int AW    = AMP_WIDTH;
  localparam int MQ    = MAX_QUBITS;
  localparam int DEPTH = 1 << MQ;
  localparam int FRAC  = AW - 2;
  localparam int NQ_W  = $clog2(MQ + 1);
  localparam int SH_W  = (MQ > 1) ? $clog2(MQ) : 1;
  localparam int P0_W  = 32 + MQ;
  localparam int M_W   = 2 * AW + 1;
  localparam int MX_W  = (P0_W > M_W) ? P0_W : M_W;
  localparam int RSH   = (2 * FRAC >= 28) ? (2 * FRAC - 28) : 0;
  localparam int LSH   = (2 * FRAC < 28) ? (28 - 2 * FRAC) : 0;
  localparam longint AMAX = (longint'(1) << (AW - 1)) - 1;
  localparam longint AMIN = -AMAX - 1;

  typedef enum logic [4:0] {
    S_IDLE, S_RDWAIT, S_FINISH,
    S_M1_RD, S_M1_SQR, S_M1_SQI, S_M1_ACC,
    S_PROB, S_SQ_GO, S_SQ_WAIT,
    S_M2_RD, S_M2_CHK, S_DRE_GO, S_DRE_WAIT, S_DIM_GO, S_DIM_WAIT, S_M2_WR
  } state_t;

  state_t state;

  // configuration
  logic [3:0]      qubit_cnt;
  logic [NQ_W-1:0] n_eff;

  // item registers
  logic [NQ_W-1:0] n_r;
  logic [SH_W-1:0] shift_r;
  logic [15:0]     rnd_r;
  logic [MQ-1:0]   j;
  logic [MQ-1:0]   js;
  logic [MQ-1:0]   mask;

  // working result
  logic            res_outcome;
  logic [16:0]     res_prob;
  logic [15:0]     res_re;
  logic [15:0]     res_im;
  logic [1:0]      res_status;

  // store
  logic [2*AW-1:0] mem [DEPTH];
  logic [2*AW-1:0] mem_q;
  logic [MQ-1:0]   mem_addr;
  logic            mem_we;
  logic [2*AW-1:0] mem_wd;
  logic signed [AW-1:0] q_re;
  logic signed [AW-1:0] q_im;

  // arithmetic
  logic [AW-1:0]   mul_op;
  logic [2*AW-1:0] mul_p;
  logic [2*AW-1:0] sq_re;
  logic [2*AW-1:0] sq_im;
  logic [MX_W-1:0] m_x;
  logic [P0_W-1:0] mag28;
  logic [P0_W-1:0] p0;
  logic [63:0]     p64;
  logic [63:0]     prb;
  logic [16:0]     p16;
  logic            zero_c;
  logic [63:0]     pc64;
  logic            zero_r;
  logic [PC_W-1:0] pc_r;
  logic [SQ_OUT_W-1:0] d_r;

  logic            sq_start;
  logic            sq_done;
  logic [SQ_OUT_W-1:0] sq_root;

  logic signed [AW-1:0] a_re;
  logic signed [AW-1:0] a_im;
  logic signed [AW-1:0] a_sel;
  logic signed [AW-1:0] new_re;
  logic signed [AW-1:0] new_im;
  logic signed [AW-1:0] scaled;
  logic [AW-1:0]   a_mag;
  logic            div_start;
  logic            div_done;
  logic            div_ovf;
  logic [AW-1:0]   div_quo;

  logic            accept;
  logic            idx_bad;
  logic            tq_bad;
  logic signed [AW-1:0] w_re;
  logic signed [AW-1:0] w_im;
  logic [15:0]     r_re;
  logic [15:0]     r_im;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // effective qubit count, clamped to 1..MAX_QUBITS
  always_comb begin
    if (qubit_cnt == 4'd0) begin
      n_eff = NQ_W'(1);
    end else if (32'(qubit_cnt) > MQ) begin
      n_eff = NQ_W'(MQ);
    end else begin
      n_eff = NQ_W'(qubit_cnt);
    end
  end

  assign idx_bad = (32'(amp_index) >> n_eff) != 32'd0;
  assign tq_bad  = 32'(target_qubit) >= 32'(n_eff);

  // write saturation to the store width
  always_comb begin
    longint vr;
    longint vi;
    vr = longint'(real_part);
    vi = longint'(imag_part);
    w_re = (vr > AMAX) ? AW'(AMAX) : (vr < AMIN) ? AW'(AMIN) : AW'(vr);
    w_im = (vi > AMAX) ? AW'(AMAX) : (vi < AMIN) ? AW'(AMIN) : AW'(vi);
  end

  assign q_re = mem_q[2*AW-1:AW];
  assign q_im = mem_q[AW-1:0];

  // read saturation to 16 bits
  always_comb begin
    longint vr;
    longint vi;
    vr = longint'(q_re);
    vi = longint'(q_im);
    r_re = (vr > 32767) ? 16'sd32767 : (vr < -32768) ? -16'sd32768 : 16'(vr);
    r_im = (vi > 32767) ? 16'sd32767 : (vi < -32768) ? -16'sd32768 : 16'(vi);
  end

  // store port
  always_comb begin
    mem_addr = j;
    mem_we   = 1'b0;
    mem_wd   = {new_re, new_im};
    if (state == S_IDLE) begin
      mem_addr = MQ'(32'(amp_index));
      mem_we   = accept && (kind == KIND_WRITE) && !idx_bad;
      mem_wd   = {w_re, w_im};
    end else if (state == S_M2_WR) begin
      mem_we   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    mem_q <= mem[mem_addr];
  end

  // shared multiplier: squares one part per cycle
  assign mul_op = (state == S_M1_SQI) ? (q_im[AW-1] ? AW'(-q_im) : AW'(q_im))
                                      : (q_re[AW-1] ? AW'(-q_re) : AW'(q_re));
  assign mul_p  = (2*AW)'(mul_op) * (2*AW)'(mul_op);

  // re^2 + im^2 in Q.28
  assign m_x   = MX_W'({1'b0, sq_re} + {1'b0, sq_im});
  assign mag28 = P0_W'((m_x >> RSH) << LSH);

  assign js   = j >> shift_r;
  assign mask = MQ'((32'd1 << n_r) - 32'd1);

  // probability of zero and chosen probability
  always_comb begin
    p64    = 64'(p0);
    prb    = (p64 + 64'd2048) >> 12;
    p16    = (prb > 64'd65536) ? 17'd65536 : 17'(prb);
    zero_c = {48'd0, rnd_r} < 64'(p16);
    if (zero_c) begin
      pc64 = p64;
    end else if (p64 < (64'd1 << 28)) begin
      pc64 = (64'd1 << 28) - p64;
    end else begin
      pc64 = 64'd0;
    end
    if (pc64 > (64'd1 << 40)) begin
      pc64 = 64'd1 << 40;
    end
  end

  assign sq_start = (state == S_SQ_GO);

  svmc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (SQ_IN_W'(pc_r) << SQ_SHIFT),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign a_sel     = (state == S_DIM_GO || state == S_DIM_WAIT) ? a_im : a_re;
  assign a_mag     = a_sel[AW-1] ? AW'(-a_sel) : AW'(a_sel);
  assign div_start = (state == S_DRE_GO) || (state == S_DIM_GO);

  svmc_div #(
    .AMP_WIDTH (AW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .mag     (a_mag),
    .divisor (d_r),
    .done    (div_done),
    .ovf     (div_ovf),
    .quo     (div_quo)
  );

  // rounded quotient back to a signed part, saturated
  always_comb begin
    if (a_mag == '0) begin
      scaled = '0;
    end else if (d_r == '0) begin
      scaled = a_sel[AW-1] ? AW'(AMIN) : AW'(AMAX);
    end else if (a_sel[AW-1]) begin
      if (div_ovf || (div_quo[AW-1] && (div_quo[AW-2:0] != '0))) begin
        scaled = AW'(AMIN);
      end else begin
        scaled = AW'(-div_quo);
      end
    end else begin
      if (div_ovf || div_quo[AW-1]) begin
        scaled = AW'(AMAX);
      end else begin
        scaled = AW'(div_quo);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      qubit_cnt <= QCOUNT_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        qubit_cnt <= cfg_wr_data;
      end
      // a new result loads in S_FINISH; otherwise a taken result clears
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            res_outcome <= 1'b0;
            res_prob    <= '0;
            res_re      <= '0;
            res_im      <= '0;
            n_r         <= n_eff;
            rnd_r       <= random_fraction;
            shift_r     <= SH_W'(32'(n_eff) - 32'd1 - 32'(target_qubit));
            j           <= '0;
            p0          <= '0;
            if ((kind == KIND_WRITE || kind == KIND_READ) && idx_bad) begin
              res_status <= ST_BAD_INDEX;
              state      <= S_FINISH;
            end else if (kind == KIND_READ) begin
              res_status <= ST_OK;
              state      <= S_RDWAIT;
            end else if (kind == KIND_MEASURE && tq_bad) begin
              res_status <= ST_BAD_QUBIT;
              state      <= S_FINISH;
            end else if (kind == KIND_MEASURE) begin
              res_status <= ST_OK;
              state      <= S_M1_RD;
            end else begin
              res_status <= ST_OK;
              state      <= S_FINISH;
            end
          end
        end

        S_RDWAIT: begin
          res_re <= r_re;
          res_im <= r_im;
          state  <= S_FINISH;
        end

        S_FINISH: begin
          if (!out_valid || out_ready) begin
            outcome   <= res_outcome;
            prob_zero <= res_prob;
            read_real <= res_re;
            read_imag <= res_im;
            status    <= res_status;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        // probability pass
        S_M1_RD: state <= S_M1_SQR;

        S_M1_SQR: begin
          sq_re <= mul_p;
          state <= S_M1_SQI;
        end

        S_M1_SQI: begin
          sq_im <= mul_p;
          state <= S_M1_ACC;
        end

        S_M1_ACC: begin
          if (!js[0]) begin
            p0 <= p0 + mag28;
          end
          if (j == mask) begin
            state <= S_PROB;
          end else begin
            j     <= j + MQ'(1);
            state <= S_M1_RD;
          end
        end

        S_PROB: begin
          res_prob    <= p16;
          res_outcome <= !zero_c;
          zero_r      <= zero_c;
          pc_r        <= PC_W'(pc64);
          state       <= S_SQ_GO;
        end

        S_SQ_GO: state <= S_SQ_WAIT;

        S_SQ_WAIT: begin
          if (sq_done) begin
            d_r   <= sq_root;
            j     <= '0;
            state <= S_M2_RD;
          end
        end

        // collapse pass
        S_M2_RD: state <= S_M2_CHK;

        S_M2_CHK: begin
          a_re <= q_re;
          a_im <= q_im;
          if (js[0] == zero_r) begin
            new_re <= '0;
            new_im <= '0;
            state  <= S_M2_WR;
          end else begin
            state  <= S_DRE_GO;
          end
        end

        S_DRE_GO: state <= S_DRE_WAIT;

        S_DRE_WAIT: begin
          if (div_done) begin
            new_re <= scaled;
            state  <= S_DIM_GO;
          end
        end

        S_DIM_GO: state <= S_DIM_WAIT;

        S_DIM_WAIT: begin
          if (div_done) begin
            new_im <= scaled;
            state  <= S_M2_WR;
          end
        end

        S_M2_WR: begin
          if (j == mask) begin
            state <= S_FINISH;
          end else begin
            j     <= j + MQ'(1);
            state <= S_M2_RD;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for state_vector_measure_collapse_unit: writes, reads and
// single-qubit measures are predicted by an in-bench amplitude model and every
// result transfer is compared field by field, across several qubit counts.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import svmc_pkg::*;

  typedef struct {
    logic [1:0]         kind;
    logic [9:0]         idx;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic [3:0]         tq;
    logic [15:0]        rnd;
  } op_t;

  typedef struct {
    logic               outcome;
    logic [16:0]        prob;
    logic signed [15:0] rd_re;
    logic signed [15:0] rd_im;
    logic [1:0]         st;
  } res_t;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [3:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = '0;
  logic [9:0] amp_index = '0;
  logic signed [15:0] real_part = '0;
  logic signed [15:0] imag_part = '0;
  logic [3:0] target_qubit = '0;
  logic [15:0] random_fraction = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic outcome;
  logic [16:0] prob_zero;
  logic signed [15:0] read_real;
  logic signed [15:0] read_imag;
  logic [1:0] status;

  state_vector_measure_collapse_unit dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .amp_index(amp_index), .real_part(real_part),
    .imag_part(imag_part), .target_qubit(target_qubit),
    .random_fraction(random_fraction),
    .out_valid(out_valid), .out_ready(out_ready),
    .outcome(outcome), .prob_zero(prob_zero), .read_real(read_real),
    .read_imag(read_imag), .status(status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  op_t  pending_ops[$];     // items waiting for the driver
  res_t expected_res[$];    // predicted results, oldest first
  logic [3:0] qcount = QCOUNT_RESET;   // register value in force
  bit   written[1024];      // entries the stimulus has written (no reads before)
  bit   calm;               // phase with no random gaps on either side
  int   errors = 0;

  // Model copy of the amplitude store (Q1.14 parts)
  logic signed [15:0] amp_re[1024];
  logic signed [15:0] amp_im[1024];

  function automatic int qubits_used(logic [3:0] c);
    if (c < 1) return 1;
    if (c > 10) return 10;
    return c;
  endfunction

  // bitwise integer square root, floor
  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // divide a kept part by sqrt(p) in Q.24, round half away from zero, saturate
  function automatic logic signed [15:0] renorm(logic signed [15:0] a, logic [63:0] d);
    logic [63:0] mag, q;
    mag = (a < 0) ? 64'(-longint'(a)) : 64'(a);
    if (mag == 0) return 16'sd0;
    if (d == 0) return (a < 0) ? -16'sd32768 : 16'sd32767;
    q = ((mag << 24) + d / 2) / d;
    if (a < 0) return (q > 64'd32768) ? -16'sd32768 : 16'(-longint'(q));
    return (q > 64'd32767) ? 16'sd32767 : 16'(q);
  endfunction

  // one accepted item -> its result, updating the model store
  function automatic res_t apply_op(op_t op);
    res_t r;
    int n, size, sh;
    logic [63:0] p0, p16, pc, d, ar, ai;
    bit zero, b;
    r = '{1'b0, 17'd0, 16'sd0, 16'sd0, ST_OK};
    n = qubits_used(qcount);
    size = 1 << n;
    case (op.kind)
      KIND_WRITE, KIND_READ: begin
        if (op.idx >= size) r.st = ST_BAD_INDEX;
        else if (op.kind == KIND_WRITE) begin
          amp_re[op.idx] = op.re;
          amp_im[op.idx] = op.im;
        end else begin
          r.rd_re = amp_re[op.idx];
          r.rd_im = amp_im[op.idx];
        end
      end
      KIND_MEASURE: begin
        if (op.tq >= n) r.st = ST_BAD_QUBIT;
        else begin
          sh = n - 1 - op.tq;
          p0 = 0;
          for (int j = 0; j < size; j++) begin
            if (((j >> sh) & 1) == 0) begin
              ar = (amp_re[j] < 0) ? 64'(-longint'(amp_re[j])) : 64'(amp_re[j]);
              ai = (amp_im[j] < 0) ? 64'(-longint'(amp_im[j])) : 64'(amp_im[j]);
              p0 += ar * ar + ai * ai;   // already Q.28 at 14 fraction bits
            end
          end
          p16 = (p0 + 64'd2048) >> 12;
          if (p16 > 64'd65536) p16 = 64'd65536;
          zero = op.rnd < p16;
          if (zero) pc = p0;
          else pc = (p0 < (64'd1 << 28)) ? (64'd1 << 28) - p0 : 64'd0;
          if (pc > (64'd1 << 40)) pc = 64'd1 << 40;
          d = int_sqrt(pc << 20);
          for (int j = 0; j < size; j++) begin
            b = ((j >> sh) & 1) != 0;
            if (b == !zero) begin
              amp_re[j] = renorm(amp_re[j], d);
              amp_im[j] = renorm(amp_im[j], d);
            end else begin
              amp_re[j] = 0;
              amp_im[j] = 0;
            end
          end
          r.outcome = !zero;
          r.prob = p16[16:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents queued items, predicts each one at its transfer
  // --------------------------------------------------------------------------
  op_t cur_op;
  int  send_gap = 0;

  always @(posedge clk) begin : driver
    logic nv;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        expected_res = {expected_res, apply_op(cur_op)};
        nv = 1'b0;
        send_gap = calm ? 0 : $urandom_range(0, 18);
      end
      if (!nv) begin
        if (send_gap > 0) send_gap--;
        else if (pending_ops.size() > 0) begin
          cur_op = pending_ops.pop_front();
          nv = 1'b1;
          kind            <= cur_op.kind;
          amp_index       <= cur_op.idx;
          real_part       <= cur_op.re;
          imag_part       <= cur_op.im;
          target_qubit    <= cur_op.tq;
          random_fraction <= cur_op.rnd;
        end
      end
      in_valid <= nv;   // single update per edge
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random out_ready stalls, one long hold-off, field compare
  // --------------------------------------------------------------------------
  int recv_gap = 0;
  int hold_off = 0;
  int results_seen = 0;
  bit held = 1'b0;

  task automatic check_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    res_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_res.size() == 0) begin
          $display("%0t unexpected result transfer, status %0d", $time, status);
          errors++;
        end else begin
          e = expected_res.pop_front();
          check_field("outcome", e.outcome, outcome);
          check_field("prob_zero", e.prob, prob_zero);
          check_field("read_real", e.rd_re, read_real);
          check_field("read_imag", e.rd_im, read_imag);
          check_field("status", e.st, status);
        end
        recv_gap = calm ? 0 : $urandom_range(0, 18);
        // long hold-off: input side keeps offering, block backs up
        if (results_seen == 60 && !held) begin
          held = 1'b1;
          hold_off = 400;
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic op_t mk(logic [1:0] k, logic [9:0] i, logic signed [15:0] re,
                             logic signed [15:0] im, logic [3:0] t, logic [15:0] f);
    op_t o;
    o.kind = k; o.idx = i; o.re = re; o.im = im; o.tq = t; o.rnd = f;
    return o;
  endfunction

  function automatic logic signed [15:0] rand_part(int lim);
    if (lim >= 32768) return 16'($urandom);
    return 16'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  task automatic queue_op(op_t o);
    pending_ops = {pending_ops, o};
  endtask

  task automatic push_write(int i, logic signed [15:0] re, logic signed [15:0] im);
    queue_op(mk(KIND_WRITE, 10'(i), re, im, 4'($urandom), 16'($urandom)));
    if (i < (1 << qubits_used(qcount))) written[i] = 1'b1;
  endtask

  // wait until nothing is queued or in flight; sampled away from the clock edge
  task automatic drain();
    @(negedge clk);
    while (pending_ops.size() > 0 || in_valid || expected_res.size() > 0)
      @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_count(logic [3:0] v);
    drain();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    qcount = v;
  endtask

  // fill_style: 0 roughly normalized, 1 full range, 2 normalized upper half zero
  task automatic fill_store(int fill_style);
    int n, size, lim;
    n = qubits_used(qcount);
    size = 1 << n;
    lim = 16384 >> ((n + 1) / 2);
    for (int j = 0; j < size; j++) begin
      if (fill_style == 1) push_write(j, rand_part(32768), rand_part(32768));
      else if (fill_style == 2 && j >= size / 2) push_write(j, 0, 0);
      else push_write(j, rand_part(lim), rand_part(lim));
    end
  endtask

  task automatic random_ops(int count);
    int n, size, r, i, lim;
    bit all_written;
    n = qubits_used(qcount);
    size = 1 << n;
    lim = 16384 >> ((n + 1) / 2);
    for (int c = 0; c < count; c++) begin
      all_written = 1'b1;
      for (int j = 0; j < size; j++) if (!written[j]) all_written = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 30) begin
        i = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                        : $urandom_range(0, size - 1);
        if ($urandom_range(0, 3) == 0) push_write(i, rand_part(32768), rand_part(32768));
        else push_write(i, rand_part(lim), rand_part(lim));
      end else if (r < 60) begin
        // read a written entry, or an index beyond the size in use
        i = $urandom_range(0, size - 1);
        if (size < 1024 && $urandom_range(0, 7) == 0) i = $urandom_range(size, 1023);
        else begin
          for (int t = 0; t < 2048 && !written[i]; t++) i = $urandom_range(0, size - 1);
          if (!written[i]) i = -1;
        end
        if (i >= 0)
          queue_op(mk(KIND_READ, 10'(i), rand_part(32768), rand_part(32768),
                      4'($urandom), 16'($urandom)));
      end else if (r < 92) begin
        // valid measures only where every entry in use holds a written value
        if (all_written && n <= 6 && $urandom_range(0, 7) != 0) begin
          queue_op(mk(KIND_MEASURE, 10'($urandom), rand_part(32768),
                      rand_part(32768), 4'($urandom_range(0, n - 1)),
                      16'($urandom)));
          for (int j = 0; j < size; j++) written[j] = 1'b1;
        end else if (n < 10 || $urandom_range(0, 1) == 0) begin
          queue_op(mk(KIND_MEASURE, 10'($urandom), rand_part(32768),
                      rand_part(32768), 4'($urandom_range(n, 15)),
                      16'($urandom)));
        end
      end else begin
        queue_op(mk(KIND_UNUSED, 10'($urandom), rand_part(32768),
                    rand_part(32768), 4'($urandom), 16'($urandom)));
      end
    end
  endtask

  initial begin
    for (int j = 0; j < 1024; j++) written[j] = 1'b0;
    calm = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset count of 10: extremes, read back, bad qubit, unused kind
    push_write(0, 16'sh7FFF, -16'sd32768);
    push_write(1023, -16'sd32768, 16'sh7FFF);
    queue_op(mk(KIND_READ, 0, 0, 0, 0, 0));
    queue_op(mk(KIND_READ, 1023, 0, 0, 0, 0));
    queue_op(mk(KIND_MEASURE, 0, 0, 0, 4'd10, 16'hFFFF));
    queue_op(mk(KIND_MEASURE, 0, 0, 0, 4'd15, 16'h0000));
    queue_op(mk(KIND_UNUSED, 10'h3FF, -16'sd1, -16'sd1, 4'hF, 16'hFFFF));

    // a count of 0 clamps to one qubit
    set_count(4'd0);
    calm = 1'b0;
    push_write(0, 16'sd16384, 0);
    push_write(1, 0, 0);
    queue_op(mk(KIND_MEASURE, 0, 0, 0, 4'd0, 16'h0000));    // certain zero
    queue_op(mk(KIND_MEASURE, 0, 0, 0, 4'd0, 16'hFFFF));
    push_write(0, -16'sd32768, -16'sd32768);                // saturated sum
    push_write(1, 16'sd32767, 16'sd32767);
    queue_op(mk(KIND_MEASURE, 0, 0, 0, 4'd0, 16'hFFFF));
    queue_op(mk(KIND_READ, 0, 0, 0, 0, 0));
    queue_op(mk(KIND_READ, 1, 0, 0, 0, 0));
    push_write(0, 0, 0);                                    // zero probability
    push_write(1, 0, 16'sd16384);
    queue_op(mk(KIND_MEASURE, 0, 0, 0, 4'd0, 16'h0000));
    queue_op(mk(KIND_READ, 1, 0, 0, 0, 0));
    queue_op(mk(KIND_MEASURE, 0, 0, 0, 4'd1, 16'h0000));   // qubit beyond
    queue_op(mk(KIND_WRITE, 2, 16'sd5, 16'sd5, 0, 0));     // index beyond
    queue_op(mk(KIND_READ, 10'd1023, 0, 0, 0, 0));
    random_ops(15);

    set_count(4'd1);
    random_ops(15);

    set_count(4'd3);
    calm = 1'b1;
    fill_store(1);
    random_ops(25);

    set_count(4'd5);
    calm = 1'b0;
    fill_store(0);
    random_ops(35);

    set_count(4'd6);
    fill_store(0);
    random_ops(30);

    set_count(4'd2);
    fill_store(2);
    random_ops(25);

    // 15 clamps to ten qubits: no full fill there, so no valid measures
    set_count(4'd15);
    calm = 1'b1;
    random_ops(20);

    set_count(4'd10);
    calm = 1'b0;
    random_ops(20);

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("timeout");
    $display("testbench NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/svmc_pkg.sv
rtl/core/svmc_sqrt.sv
rtl/core/svmc_div.sv
rtl/core/state_vector_measure_collapse_unit.sv
bench/testbench.sv
